// ===== hw/rtl/wrt_pkg.sv =====
package wrt_pkg;

    localparam int DEF_WIPER_BITS = 8;

    localparam logic [15:0] DEF_HIGH_VOLTAGE_THRESHOLD = 16'd4500;
    localparam logic [15:0] DEF_HIGH_TOLERANCE         = 16'd500;
    localparam logic [15:0] DEF_LOW_TOLERANCE          = 16'd90;

    localparam logic [1:0] REG_HIGH_VOLTAGE_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HIGH_TOLERANCE         = 2'd1;
    localparam logic [1:0] REG_LOW_TOLERANCE          = 2'd2;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_MEASURE = 1'b1;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_RAMP  = 2'd1;
    localparam logic [1:0] PH_FINAL = 2'd2;

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_MEASURE = 2'd1;
    localparam logic [1:0] ACT_DONE    = 2'd2;
    localparam logic [1:0] ACT_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  phase;
        logic        ramp_up;
        logic [15:0] previous_error;
        logic [15:0] last_target;
    } t_state;

    typedef struct packed {
        logic [15:0] high_voltage_threshold;
        logic [15:0] high_tolerance;
        logic [15:0] low_tolerance;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  action;
        logic        in_tolerance;
        logic [15:0] requested_mv;
    } t_res;

endpackage

// ===== hw/rtl/wrt_core.sv =====
module wrt_core #(
    parameter int WIPER_BITS = wrt_pkg::DEF_WIPER_BITS
) (
    input  wrt_pkg::t_state        i_state,
    input  logic [WIPER_BITS-1:0]  i_wiper,
    input  wrt_pkg::t_cfg          i_cfg,
    input  logic                   i_command,
    input  logic [15:0]            i_target_mv,
    input  logic [7:0]             i_wiper_now,
    input  logic [15:0]            i_measured_mv,
    output wrt_pkg::t_state        o_state,
    output logic [WIPER_BITS-1:0]  o_wiper,
    output wrt_pkg::t_res          o_res,
    output logic [7:0]             o_wiper_code
);
    import wrt_pkg::*;

    localparam int WIDE = (WIPER_BITS > 8) ? WIPER_BITS : 8;
    localparam logic [WIPER_BITS-1:0] WIPER_MAX = {WIPER_BITS{1'b1}};

    function automatic logic [WIPER_BITS-1:0] step(input logic [WIPER_BITS-1:0] w,
                                                   input logic up);
        logic [WIPER_BITS-1:0] r;
        r = w;
        if (up) begin
            if (w != WIPER_MAX) r = w + 1'b1;
        end else begin
            if (w != '0) r = w - 1'b1;
        end
        return r;
    endfunction

    logic [WIDE-1:0]       wnow_wide;
    logic [WIPER_BITS-1:0] wnow;
    logic [15:0]           ref_mv;
    logic [15:0]           err;
    logic                  done;
    logic [15:0]           tol;
    logic [WIDE-1:0]       code_wide;

    assign wnow_wide = WIDE'(i_wiper_now);
    assign wnow      = wnow_wide[WIPER_BITS-1:0];
    assign ref_mv    = (i_command == CMD_START) ? i_target_mv : i_state.last_target;
    assign err       = (ref_mv < i_measured_mv) ? (i_measured_mv - ref_mv)
                                                : (ref_mv - i_measured_mv);
    assign done      = i_state.ramp_up ? ((i_measured_mv > i_state.last_target) ||
                                          (i_wiper == WIPER_MAX))
                                       : ((i_measured_mv < i_state.last_target) ||
                                          (i_wiper == '0));
    assign tol       = (i_state.last_target > i_cfg.high_voltage_threshold) ?
                       i_cfg.high_tolerance : i_cfg.low_tolerance;

    always_comb begin
        o_state             = i_state;
        o_wiper             = i_wiper;
        o_res.action        = ACT_IGNORED;
        o_res.in_tolerance  = 1'b0;
        if (i_command == CMD_START) begin
            o_state.last_target    = i_target_mv;
            o_state.previous_error = err;
            o_state.ramp_up        = i_target_mv > i_measured_mv;
            o_wiper                = step(wnow, i_target_mv > i_measured_mv);
            o_state.phase          = PH_RAMP;
            o_res.action           = ACT_WRITE;
        end else if (i_state.phase == PH_RAMP) begin
            o_state.previous_error = err;
            if (!done) begin
                o_wiper      = step(i_wiper, i_state.ramp_up);
                o_res.action = ACT_WRITE;
            end else begin
                o_state.phase = PH_FINAL;
                if (err > i_state.previous_error) begin
                    o_wiper      = step(i_wiper, !i_state.ramp_up);
                    o_res.action = ACT_WRITE;
                end else begin
                    o_res.action = ACT_MEASURE;
                end
            end
        end else if (i_state.phase == PH_FINAL) begin
            o_res.in_tolerance = err < tol;
            o_state.phase      = PH_IDLE;
            o_res.action       = ACT_DONE;
        end
        o_res.requested_mv = o_state.last_target;
    end

    assign code_wide    = WIDE'(o_wiper);
    assign o_wiper_code = code_wide[7:0];

endmodule

// ===== hw/rtl/wiper_ramp_voltage_trim_top.sv =====
// Channel   Direction  tdata                                   tuser
// s_axis    in         target_mv, wiper_now, measured_mv       command
// m_axis    out        wiper_code, in_tolerance, requested_mv  action
// Config    in         write enable, register index, 16-bit data
//
// Every request's result is registered and valid in the cycle after the request is taken.
// One request per cycle is sustained while the master side is ready; the result register is the only stage.
// The slave side stalls only while a result waits and the master side is not ready.
// Reset is synchronous and active low; configuration returns to its defaults.
module wiper_ramp_voltage_trim_top #(
    parameter int WIPER_BITS = wrt_pkg::DEF_WIPER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // target_mv, wiper_now, measured_mv
    input  logic [0:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // wiper_code, in_tolerance, requested_mv, zero pad
    output logic [1:0]  m_axis_tuser   // action
);
    import wrt_pkg::*;

    t_cfg                  r_cfg;
    t_state                r_state;
    t_state                n_state;
    logic [WIPER_BITS-1:0] r_wiper;
    logic [WIPER_BITS-1:0] n_wiper;
    logic                  r_out_valid;
    t_res                  r_res;
    t_res                  n_res;
    logic [7:0]            r_code;
    logic [7:0]            n_code;
    logic                  accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    wrt_core #(
        .WIPER_BITS(WIPER_BITS)
    ) u_core (
        .i_state      (r_state),
        .i_wiper      (r_wiper),
        .i_cfg        (r_cfg),
        .i_command    (s_axis_tuser[0]),
        .i_target_mv  (s_axis_tdata[15:0]),
        .i_wiper_now  (s_axis_tdata[23:16]),
        .i_measured_mv(s_axis_tdata[39:24]),
        .o_state      (n_state),
        .o_wiper      (n_wiper),
        .o_res        (n_res),
        .o_wiper_code (n_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_voltage_threshold <= DEF_HIGH_VOLTAGE_THRESHOLD;
            r_cfg.high_tolerance         <= DEF_HIGH_TOLERANCE;
            r_cfg.low_tolerance          <= DEF_LOW_TOLERANCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_HIGH_VOLTAGE_THRESHOLD: r_cfg.high_voltage_threshold <= i_cfg_data;
                REG_HIGH_TOLERANCE:         r_cfg.high_tolerance         <= i_cfg_data;
                REG_LOW_TOLERANCE:          r_cfg.low_tolerance          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '{phase: PH_IDLE, ramp_up: 1'b0, previous_error: '0,
                             last_target: '0};
            r_wiper     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_state     <= n_state;
                r_wiper     <= n_wiper;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res  <= n_res;
            r_code <= n_code;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_res.action;
    assign m_axis_tdata  = {7'd0, r_res.requested_mv, r_res.in_tolerance, r_code};

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("Input stalled with no result pending.");

    a_start_begins_ramp : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser[0] == CMD_START |=>
            r_state.phase == PH_RAMP && m_axis_tvalid && m_axis_tuser == ACT_WRITE)
        else $error("Start request did not begin a ramp.");

    a_idle_measure_ignored : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && s_axis_tuser[0] == CMD_MEASURE && r_state.phase == PH_IDLE |=>
            r_state.phase == PH_IDLE && m_axis_tuser == ACT_IGNORED &&
            r_wiper == $past(r_wiper))
        else $error("Measurement while idle changed state.");

    a_pass_only_on_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ACT_DONE |-> !m_axis_tdata[8])
        else $error("Tolerance flag set on a result that is not a finish.");

endmodule
